@@ src/pqnb_pkg.sv @@
`default_nettype none
package pqnb_pkg;

  // Fixed-point format of every coordinate and matrix element
  localparam int FRAC_BITS = 16;
  localparam int Q_W       = 32;

  // Clip coordinate: three floored products plus translation
  localparam int PROD_W = 2 * Q_W;
  localparam int CLIP_W = PROD_W - FRAC_BITS + 2;

  // Divider: quotient magnitude bits and remainder width
  localparam int QBITS   = Q_W - 1;
  localparam int REM_W   = CLIP_W + QBITS;
  localparam int DIV_LAT = QBITS + 1;

  // Corner queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Configuration port
  localparam int NUM_REGS = 8;
  localparam int REG_W    = 64;
  localparam int REG_AW   = $clog2(NUM_REGS);
  localparam int ADDR_W   = REG_AW + 3;

  localparam logic signed [Q_W-1:0] ONE_Q     = Q_W'(1 << FRAC_BITS);
  localparam logic signed [Q_W-1:0] NEG_ONE_Q = -ONE_Q;
  localparam logic signed [Q_W-1:0] Q_MAX     = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic signed [Q_W-1:0] Q_MIN     = {1'b1, {(Q_W-1){1'b0}}};

  typedef logic signed [Q_W-1:0]    q_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [CLIP_W-1:0] clip_t;
  typedef q_t [3:0][3:0]            mat_t;

  // Identity matrix after reset; one ONE per diagonal element
  localparam logic [REG_W-1:0] REG_RESET [NUM_REGS] = '{
    REG_W'(ONE_Q), '0,
    REG_W'(ONE_Q) << Q_W, '0,
    '0, REG_W'(ONE_Q),
    '0, REG_W'(ONE_Q) << Q_W
  };

  typedef struct packed {
    logic signed [Q_W-1:0] corner_min_x;
    logic signed [Q_W-1:0] corner_min_y;
    logic signed [Q_W-1:0] plane_z;
    logic signed [Q_W-1:0] corner_max_x;
    logic signed [Q_W-1:0] corner_max_y;
  } in_item_t;

  typedef struct packed {
    logic signed [Q_W-1:0] ndc_min_x;
    logic signed [Q_W-1:0] ndc_min_y;
    logic signed [Q_W-1:0] ndc_max_x;
    logic signed [Q_W-1:0] ndc_max_y;
    logic                  in_view;
  } out_item_t;

  // One corner on its way from front to back
  typedef struct packed {
    logic signed [Q_W-1:0] x;
    logic signed [Q_W-1:0] y;
    logic signed [Q_W-1:0] z;
    logic                  last;
  } corner_t;

  // Queue head as seen by the back part
  typedef struct packed {
    logic    valid;
    corner_t data;
  } head_t;

endpackage
`default_nettype wire

@@ src/projected_quad_ndc_bounds.sv @@
`default_nettype none
// Projected rectangle bounds: each item is an axis-aligned rectangle at height
// plane_z; its four corners are transformed by the 4x4 matrix held in the eight
// 64-bit registers (byte address 8*i, even column in the low word), divided by w
// and reduced to an NDC bounding box with a visibility flag. All values are
// signed Q16.16. The front part issues one corner per cycle into a four-entry
// queue while it has room, and the back part runs each corner through a
// multiply stage, a sum stage and three 32-stage bit-per-stage dividers; the
// four corners of an item share this one transform and divide pipeline, which
// moves unless a finished result is stalled at the output.
// Matrix registers may be written only while no item is in flight.
module projected_quad_ndc_bounds (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          item_valid,
  output logic                               item_stall,
  input  wire pqnb_pkg::in_item_t            item,
  output logic                               result_valid,
  input  wire logic                          result_stall,
  output pqnb_pkg::out_item_t                result,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [pqnb_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [pqnb_pkg::REG_W-1:0]    pwdata,
  output logic [pqnb_pkg::REG_W-1:0]         prdata,
  output logic                               pready
);
  import pqnb_pkg::*;

  logic [REG_W-1:0]  regs [NUM_REGS];
  logic [REG_AW-1:0] ridx;
  mat_t              m;
  logic              full;
  logic              push;
  logic              pop;
  corner_t           corner;
  head_t             head;

  // Register file
  assign pready = 1'b1;
  assign ridx   = paddr[ADDR_W-1:3];
  assign prdata = regs[ridx];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs[i] <= REG_RESET[i];
      end
    end else if (psel && penable && pwrite && pready) begin
      regs[ridx] <= pwdata;
    end
  end

  // Unpack the matrix: row r, columns 2j and 2j+1 share one register
  for (genvar r = 0; r < 4; r++) begin : g_row
    for (genvar c = 0; c < 4; c++) begin : g_col
      assign m[r][c] = regs[r*2 + c/2][(c%2)*Q_W +: Q_W];
    end
  end

  pqnb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .full       (full),
    .push       (push),
    .corner     (corner)
  );

  pqnb_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (corner),
    .full  (full),
    .pop   (pop),
    .head  (head)
  );

  pqnb_back u_back (
    .clk          (clk),
    .rst          (rst),
    .m            (m),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
`default_nettype wire

@@ src/pqnb_front.sv @@
`default_nettype none
module pqnb_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_stall,
  input  wire pqnb_pkg::in_item_t item,
  input  wire logic              full,
  output logic                   push,
  output pqnb_pkg::corner_t      corner
);
  import pqnb_pkg::*;

  in_item_t   cur;
  logic       busy;
  logic [1:0] cnt;
  logic       take;

  // Emit one corner per cycle while the queue has room
  assign push = busy && !full;
  assign item_stall = busy && !(push && cnt == 2'd3);
  assign take = item_valid && !item_stall;

  always_comb begin
    corner.x    = cnt[1] ? cur.corner_max_x : cur.corner_min_x;
    corner.y    = cnt[0] ? cur.corner_max_y : cur.corner_min_y;
    corner.z    = cur.plane_z;
    corner.last = (cnt == 2'd3);
  end

  // Hold the item and advance through its corners
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (take) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (push) begin
      cnt <= cnt + 2'd1;
      if (cnt == 2'd3) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur <= item;
    end
  end

endmodule
`default_nettype wire

@@ src/pqnb_fifo.sv @@
`default_nettype none
module pqnb_fifo (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire pqnb_pkg::corner_t wdata,
  output logic                  full,
  input  wire logic             pop,
  output pqnb_pkg::head_t       head
);
  import pqnb_pkg::*;

  corner_t              mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wptr;
  logic [FIFO_AW-1:0]   rptr;
  logic [FIFO_AW:0]     count;

  assign full       = (count == (FIFO_AW+1)'(FIFO_DEPTH));
  assign head.valid = (count != '0);
  assign head.data  = mem[rptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full)) else $error("corner queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && !head.valid)) else $error("corner queue underflow");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= (FIFO_AW+1)'(FIFO_DEPTH)) else $error("corner queue count out of range");

endmodule
`default_nettype wire

@@ src/pqnb_div.sv @@
`default_nettype none
module pqnb_div (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire pqnb_pkg::clip_t     num,
  input  wire pqnb_pkg::clip_t     den,
  output pqnb_pkg::q_t             quo
);
  import pqnb_pkg::*;

  logic [CLIP_W-1:0] un;
  logic [CLIP_W-1:0] ud;
  logic              ovf0;

  logic [REM_W-1:0]  rem_s  [0:QBITS-1];
  logic [CLIP_W-1:0] ud_s   [0:QBITS-1];
  logic [QBITS-1:0]  q_s    [0:QBITS];
  logic              neg_s  [0:QBITS];
  logic              zero_s [0:QBITS];
  logic              ovf_s  [0:QBITS];
  logic [Q_W-1:0]    qv;

  // Magnitudes; quotient overflows when num * 2^F >= den * 2^31
  always_comb begin
    un   = num[CLIP_W-1] ? (~num + 1'b1) : num;
    ud   = den[CLIP_W-1] ? (~den + 1'b1) : den;
    ovf0 = ((REM_W'(un) << FRAC_BITS) >= (REM_W'(ud) << QBITS));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_s[0]  <= REM_W'(un) << FRAC_BITS;
      ud_s[0]   <= ud;
      q_s[0]    <= '0;
      neg_s[0]  <= num[CLIP_W-1] ^ den[CLIP_W-1];
      zero_s[0] <= (num == '0);
      ovf_s[0]  <= ovf0;
    end
  end

  // One quotient bit per stage, most significant first
  for (genvar k = 1; k <= QBITS; k++) begin : g_stage
    localparam int SH = QBITS - k;
    logic [REM_W-1:0] trial;
    logic             ge;

    always_comb begin
      trial = REM_W'(ud_s[k-1]) << SH;
      ge    = (rem_s[k-1] >= trial);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_s[k]    <= {q_s[k-1][QBITS-2:0], ge};
        neg_s[k]  <= neg_s[k-1];
        zero_s[k] <= zero_s[k-1];
        ovf_s[k]  <= ovf_s[k-1];
      end
    end

    if (k < QBITS) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_s[k] <= ge ? (rem_s[k-1] - trial) : rem_s[k-1];
          ud_s[k]  <= ud_s[k-1];
        end
      end
    end
  end

  // Apply sign, saturation and zero numerator
  always_comb begin
    qv = {1'b0, q_s[QBITS]};
    if (zero_s[QBITS]) begin
      quo = '0;
    end else if (ovf_s[QBITS]) begin
      quo = neg_s[QBITS] ? Q_MIN : Q_MAX;
    end else begin
      quo = neg_s[QBITS] ? q_t'(-qv) : q_t'(qv);
    end
  end

endmodule
`default_nettype wire

@@ src/pqnb_back.sv @@
`default_nettype none
module pqnb_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire pqnb_pkg::mat_t    m,
  input  wire pqnb_pkg::head_t   head,
  output logic                   pop,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output pqnb_pkg::out_item_t    result
);
  import pqnb_pkg::*;

  localparam int PIPE_N = DIV_LAT + 2;

  logic              adv;
  logic [PIPE_N-1:0] vld;
  logic [PIPE_N-1:0] lst;

  q_t    vec    [3];
  prod_t prod   [3][4];
  clip_t clip   [4];
  clip_t clip_n [4];
  q_t    nd     [3];

  q_t         lo [3];
  q_t         hi [3];
  q_t         nlo [3];
  q_t         nhi [3];
  logic [2:0] behind;
  logic [2:0] nbehind;
  logic       beh;
  out_item_t  res;

  // The whole back pipe moves unless a finished item waits
  assign adv = !(result_valid && result_stall);
  assign pop = adv && head.valid;

  always_comb begin
    vec[0] = head.data.x;
    vec[1] = head.data.y;
    vec[2] = head.data.z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[PIPE_N-2:0], head.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lst <= {lst[PIPE_N-2:0], head.data.last};
    end
  end

  // Stage one: the twelve products of the corner and the matrix
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 4; c++) begin
          prod[r][c] <= prod_t'(vec[r]) * prod_t'(m[r][c]);
        end
      end
    end
  end

  // Stage two: floor each product and add the translation row
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      clip_n[c] = clip_t'(prod[0][c] >>> FRAC_BITS) + clip_t'(prod[1][c] >>> FRAC_BITS)
                + clip_t'(prod[2][c] >>> FRAC_BITS) + clip_t'(m[3][c]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      clip <= clip_n;
    end
  end

  // Divide x, y and z by w
  for (genvar a = 0; a < 3; a++) begin : g_div
    pqnb_div u_div (
      .clk (clk),
      .en  (adv),
      .num (clip[a]),
      .den (clip[3]),
      .quo (nd[a])
    );
  end

  // Fold the corner into the running box and form the result
  always_comb begin
    beh     = nd[2][Q_W-1];
    nbehind = behind + {2'b00, beh};
    for (int a = 0; a < 3; a++) begin
      nlo[a] = (!beh && nd[a] < lo[a]) ? nd[a] : lo[a];
      nhi[a] = (!beh && nd[a] > hi[a]) ? nd[a] : hi[a];
    end
    res.in_view = 1'b1;
    if (nbehind == 3'd4) begin
      res.ndc_min_x = '0;
      res.ndc_min_y = '0;
      res.ndc_max_x = '0;
      res.ndc_max_y = '0;
      res.in_view   = 1'b0;
    end else if (nbehind != 3'd0) begin
      res.ndc_min_x = NEG_ONE_Q;
      res.ndc_min_y = NEG_ONE_Q;
      res.ndc_max_x = ONE_Q;
      res.ndc_max_y = ONE_Q;
    end else begin
      res.ndc_min_x = (nlo[0] < NEG_ONE_Q) ? NEG_ONE_Q : nlo[0];
      res.ndc_min_y = (nlo[1] < NEG_ONE_Q) ? NEG_ONE_Q : nlo[1];
      res.ndc_max_x = (nhi[0] > ONE_Q) ? ONE_Q : nhi[0];
      res.ndc_max_y = (nhi[1] > ONE_Q) ? ONE_Q : nhi[1];
      if (res.ndc_min_x >= ONE_Q || res.ndc_min_y >= ONE_Q || nlo[2] >= ONE_Q ||
          res.ndc_max_x <= NEG_ONE_Q || res.ndc_max_y <= NEG_ONE_Q ||
          nhi[2] <= NEG_ONE_Q) begin
        res.in_view = 1'b0;
      end
    end
  end

  // Keep the running box; restart it after the last corner
  always_ff @(posedge clk) begin
    if (rst) begin
      behind <= '0;
      for (int a = 0; a < 3; a++) begin
        lo[a] <= Q_MAX;
        hi[a] <= Q_MIN;
      end
    end else if (adv && vld[PIPE_N-1]) begin
      if (lst[PIPE_N-1]) begin
        behind <= '0;
        for (int a = 0; a < 3; a++) begin
          lo[a] <= Q_MAX;
          hi[a] <= Q_MIN;
        end
      end else begin
        behind <= nbehind;
        lo     <= nlo;
        hi     <= nhi;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= vld[PIPE_N-1] && lst[PIPE_N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv && vld[PIPE_N-1] && lst[PIPE_N-1]) begin
      result <= res;
    end
  end

  a_behind_range: assert property (@(posedge clk) disable iff (rst)
    behind < 3'd4) else $error("behind count kept past last corner");
  a_box_low: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.ndc_min_x >= NEG_ONE_Q && result.ndc_min_y >= NEG_ONE_Q))
    else $error("box minimum below the screen edge");
  a_box_high: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.ndc_max_x <= ONE_Q && result.ndc_max_y <= ONE_Q))
    else $error("box maximum above the screen edge");

endmodule
`default_nettype wire
